@@ rtl/core/weighted_random_walk_step_macros.svh @@
// Assertion macros for the weighted random walk step block.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef WEIGHTED_RANDOM_WALK_STEP_MACROS_SVH
`define WEIGHTED_RANDOM_WALK_STEP_MACROS_SVH
// implication checked each clock, disabled in reset
`define WRW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked each clock, disabled in reset
`define WRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/wrw_pkg.sv @@
// Package for the weighted random walk step block: payload structs, codes, sizes.
// No dependencies.
`default_nettype none
package wrw_pkg;
   localparam int NodeCount  = 1024;
   localparam int EdgeCount  = 4096;
   localparam int MaxWalk    = 1024;
   localparam int NodeW      = 10;
   localparam int SlotW      = 12;
   localparam int OffW       = 13;
   localparam int WeightW    = 16;
   localparam int SumW       = 28;
   localparam int TgtW       = 28;

   localparam logic [1:0] REQ_WR_OFFSET = 2'd0;
   localparam logic [1:0] REQ_WR_EDGE   = 2'd1;
   localparam logic [1:0] REQ_START     = 2'd2;
   localparam logic [1:0] REQ_STEP      = 2'd3;

   localparam logic CSR_WALK_LENGTH    = 1'b0;
   localparam logic CSR_RESTART_PERIOD = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [10:0] node_id;
      logic [12:0] edge_offset;
      logic [11:0] edge_slot;
      logic [9:0]  edge_target;
      logic [15:0] edge_weight;
      logic [15:0] draw;
   } req_type;

   typedef struct packed {
      logic [9:0] walk_node;
      logic [9:0] position;
      logic       last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture request fields, launch offset reads
      logic load_off;     // capture offset table read data
      logic mod_step;     // one bit of the position remainder
      logic scan_init;    // scan pointer to first edge
      logic scan_step;    // scan pointer advances, accumulate
      logic pass2;        // second pass: cumulative select
      logic drop_excl;    // sum was zero, redo without exclusion
      logic calc_tgt;     // compute draw*sum target
      logic emit_start;   // result for start request
      logic emit_step;    // result for step request
      logic emit_restart; // step result returns to origin
      logic emit_stay;    // step result stays on node
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic       no_edges;
      logic       scan_done;
      logic       picked;
      logic       sum_zero;
      logic       excl_on;
      logic       walk_active;
      logic       restart_hit;
      logic       start_ok;
      logic       mod_last;
   } sts_type;
endpackage
`default_nettype wire

@@ rtl/core/weighted_random_walk_step.sv @@
// Top level of the weighted random walk step block: CSR registers, wiring.
// Depends on wrw_pkg, wrw_ctrl and wrw_dp.
//
// Usage:
//   A request is taken when start is high and busy is low. Request kinds:
//   offset write and edge write (table loads, no result), start walk
//   (emits the start node at position 0 if its id is below NodeCount) and
//   take step (emits the next node while a walk is active). Each result shows
//   on rsp_data for one cycle with rsp_valid high; the receiver cannot stall,
//   so nothing is held back. A step first works out the remainder of its
//   position by the restart period; one that restarts or stays then emits
//   its result. Otherwise it makes sequential passes over the node's edge
//   list through one edge table port (sum, then cumulative select), with the
//   sum pass run again when the backtrack edge held all the weight.
//   One request is in flight at a time.
//   Reset clears the walk state and the CSRs (walk_length 16, restart 0);
//   the tables are undefined until written.
//   CSR writes are taken at once through csr_we/csr_index/csr_wdata.
`default_nettype none
module weighted_random_walk_step import wrw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic [10:0] csr_wdata
);
   logic [10:0] walk_length_ff;
   logic [9:0]  restart_period_ff;
   ctl_type ctl;
   sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_length_ff    <= 11'd16;
         restart_period_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WALK_LENGTH:    walk_length_ff    <= csr_wdata;
            CSR_RESTART_PERIOD: restart_period_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   wrw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_kind(req_data.req_type),
      .sts(sts), .busy(busy), .ctl(ctl)
   );

   wrw_dp u_dp (
      .clock(clock), .reset(reset), .req(req_data), .ctl(ctl),
      .walk_length(walk_length_ff), .restart_period(restart_period_ff),
      .sts(sts), .rsp_valid(rsp_valid), .rsp(rsp_data)
   );
endmodule
`default_nettype wire

@@ rtl/core/wrw_ctrl.sv @@
// Controller state machine for the weighted random walk step block.
// Depends on wrw_pkg and the assertion macro header.
`default_nettype none
`include "weighted_random_walk_step_macros.svh"
module wrw_ctrl import wrw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic [1:0] req_kind,
   input  wire sts_type sts,
   output logic         busy,
   output ctl_type      ctl
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDOFF = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_TGT  = 3'd4;
   localparam logic [2:0] S_SEL  = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;
   localparam logic [2:0] S_MOD  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= REQ_WR_OFFSET;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      ctl      = '0;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load_req = 1'b1;
               kind_in = req_kind;
               if (req_kind inside {REQ_STEP, REQ_START}) state_in = S_RDOFF;
            end
         end
         S_RDOFF: begin
            ctl.load_off = 1'b1;
            ctl.mod_step = 1'b1;
            state_in = (kind_ff == REQ_START) ? S_DEC : S_MOD;
         end
         S_MOD: begin
            // remainder of position by restart period, one bit a cycle
            ctl.mod_step = 1'b1;
            if (sts.mod_last) state_in = S_DEC;
         end
         S_DEC: begin
            if (kind_ff == REQ_START) begin
               ctl.emit_start = sts.start_ok;
               state_in = S_IDLE;
            end else if (!sts.walk_active) begin
               state_in = S_IDLE;
            end else if (sts.restart_hit) begin
               ctl.emit_step = 1'b1;
               ctl.emit_restart = 1'b1;
               state_in = S_IDLE;
            end else if (sts.no_edges) begin
               ctl.emit_step = 1'b1;
               ctl.emit_stay = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctl.scan_init = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sts.scan_done) begin
               if (sts.sum_zero && sts.excl_on) begin
                  ctl.drop_excl = 1'b1;
                  ctl.scan_init = 1'b1;
               end else begin
                  state_in = S_TGT;
               end
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         S_TGT: begin
            ctl.calc_tgt  = 1'b1;
            ctl.scan_init = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            ctl.pass2 = 1'b1;
            if (sts.picked || sts.scan_done) state_in = S_EMIT;
            else ctl.scan_step = 1'b1;
         end
         S_EMIT: begin
            ctl.emit_step = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `WRW_ASSERT_IMPL(a_emit_one, clock, reset, 1'b1, !(ctl.emit_start && ctl.emit_step), "two results")
   `WRW_ASSERT_IMPL(a_idle_accept, clock, reset, ctl.load_req, state_ff == S_IDLE, "accept while busy")
   `WRW_ASSERT_NEXT(a_emit_idle, clock, reset, ctl.emit_step || ctl.emit_start, state_ff == S_IDLE, "no idle")
endmodule
`default_nettype wire

@@ rtl/core/wrw_dp.sv @@
// Datapath for the weighted random walk step block: tables, walk state, scan.
// Depends on wrw_pkg.
`default_nettype none
module wrw_dp import wrw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire ctl_type ctl,
   input  wire logic [10:0] walk_length,
   input  wire logic [9:0]  restart_period,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_type      rsp
);
   logic [OffW-1:0]    off_mem [NodeCount+1];
   logic [NodeW-1:0]   nbr_mem [EdgeCount];
   logic [WeightW-1:0] wgt_mem [EdgeCount];

   req_type req_ff;
   logic [OffW-1:0] off_a_ff, off_b_ff;
   logic [OffW-1:0] first_ff, end_ff;
   logic [9:0] cur_ff, cur_in, org_ff, org_in, prv_ff, prv_in, cnt_ff, cnt_in;
   logic act_ff, act_in;
   logic [OffW-1:0] ptr_ff;       // address of edge being read
   logic            rd_ok_ff;     // edge data below is valid
   logic [OffW-1:0] ed_slot_ff;
   logic [NodeW-1:0]   ed_nbr_ff;
   logic [WeightW-1:0] ed_wgt_ff;
   logic [SumW-1:0] sum_ff, cum_ff;
   logic [TgtW-1:0] tgt_ff;
   logic excl_ff;
   logic [NodeW-1:0] pick_ff, first_nbr_ff;
   logic picked_ff;
   logic [10:0] pos;
   logic [10:0] eff_len;
   logic [SumW-1:0] cum_next;
   logic            edge_in;
   logic [NodeW-1:0] next_node;
   logic [10:0] div_ff;           // position bits still to shift in
   logic [10:0] rem_ff;           // partial remainder
   logic [3:0]  rem_cnt_ff;
   logic [10:0] rem_shift;

   // offset table and edge table writes, registered reads
   always_ff @(posedge clock) begin
      if (ctl.load_req && req.req_type == REQ_WR_OFFSET && req.node_id <= 11'(NodeCount))
         off_mem[req.node_id] <= req.edge_offset;
      if (ctl.load_req && req.req_type == REQ_WR_EDGE) begin
         nbr_mem[req.edge_slot] <= req.edge_target;
         wgt_mem[req.edge_slot] <= req.edge_weight;
      end
      if (ctl.load_req) begin
         off_a_ff <= off_mem[{1'b0, cur_ff}];
         off_b_ff <= off_mem[11'({1'b0, cur_ff}) + 11'd1];
      end
      ed_nbr_ff <= nbr_mem[ptr_ff[SlotW-1:0]];
      ed_wgt_ff <= wgt_mem[ptr_ff[SlotW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) req_ff <= req;
      if (ctl.load_off) begin
         first_ff <= (off_a_ff > 13'(EdgeCount)) ? 13'(EdgeCount) : off_a_ff;
         end_ff   <= (off_b_ff > 13'(EdgeCount)) ? 13'(EdgeCount) : off_b_ff;
      end
   end

   assign eff_len = (walk_length == 11'd0) ? 11'd1 :
                    (walk_length > 11'(MaxWalk)) ? 11'(MaxWalk) : walk_length;
   assign pos = {1'b0, cnt_ff} + 11'd1;

   // pos mod restart_period, restoring remainder, position bits taken MSB first
   assign rem_shift = {rem_ff[9:0], div_ff[10]};

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         div_ff     <= pos;
         rem_ff     <= '0;
         rem_cnt_ff <= 4'd11;
      end else if (ctl.mod_step && rem_cnt_ff != 4'd0) begin
         div_ff     <= {div_ff[9:0], 1'b0};
         rem_ff     <= (rem_shift >= {1'b0, restart_period}) ?
                       rem_shift - {1'b0, restart_period} : rem_shift;
         rem_cnt_ff <= rem_cnt_ff - 4'd1;
      end
   end

   assign edge_in = ptr_ff < end_ff;
   assign cum_next = (excl_ff && ed_nbr_ff == prv_ff) ? cum_ff : cum_ff + SumW'(ed_wgt_ff);

   assign sts.no_edges    = (end_ff <= first_ff);
   assign sts.scan_done   = rd_ok_ff && (ed_slot_ff + 13'd1 >= end_ff);
   assign sts.picked      = picked_ff;
   assign sts.sum_zero    = (cum_next == '0);
   assign sts.excl_on     = excl_ff;
   assign sts.walk_active = act_ff;
   assign sts.restart_hit = (restart_period != 10'd0) && (rem_ff[9:0] == 10'd0);
   assign sts.start_ok    = (req_ff.node_id < 11'(NodeCount));
   assign sts.mod_last    = (rem_cnt_ff == 4'd1);

   // target = ceil(draw*sum/65536)
   logic [SumW+15:0] prod;
   assign prod = req_ff.draw * sum_ff;

   always_ff @(posedge clock) begin
      if (ctl.scan_init) begin
         ptr_ff   <= first_ff;
         rd_ok_ff <= 1'b0;
         cum_ff   <= '0;
         picked_ff <= 1'b0;
      end else if (ctl.scan_step || (ctl.pass2 && !picked_ff)) begin
         if (edge_in) ptr_ff <= ptr_ff + 13'd1;
         rd_ok_ff   <= 1'b1;
         ed_slot_ff <= ptr_ff;
         if (rd_ok_ff) begin
            cum_ff <= cum_next;
            if (ctl.pass2 && tgt_ff <= TgtW'(cum_next)) begin
               picked_ff <= 1'b1;
               pick_ff   <= ed_nbr_ff;
            end
            if (ed_slot_ff == first_ff) first_nbr_ff <= ed_nbr_ff;
         end
      end
      // capture the first-pass sum when the scan finishes
      if (sts.scan_done && !ctl.pass2 && !ctl.scan_init && !ctl.calc_tgt) sum_ff <= cum_next;
      if (ctl.calc_tgt) tgt_ff <= TgtW'((prod + (SumW+16)'(16'hFFFF)) >> 16);
      if (ctl.load_off) excl_ff <= (pos >= 11'd2);
      else if (ctl.drop_excl) excl_ff <= 1'b0;
   end

   assign next_node = ctl.emit_restart ? org_ff :
                      ctl.emit_stay ? cur_ff :
                      picked_ff ? pick_ff : first_nbr_ff;

   always_comb begin
      cur_in = cur_ff; org_in = org_ff; prv_in = prv_ff; cnt_in = cnt_ff;
      act_in = act_ff;
      rsp = '0;
      rsp_valid = 1'b0;
      if (ctl.emit_start) begin
         cur_in = req_ff.node_id[9:0]; org_in = req_ff.node_id[9:0];
         prv_in = '0; cnt_in = '0;
         act_in = (eff_len > 11'd1);
         rsp_valid = 1'b1;
         rsp.walk_node = req_ff.node_id[9:0];
         rsp.position = '0;
         rsp.last = !(eff_len > 11'd1);
      end else if (ctl.emit_step) begin
         prv_in = cur_ff;
         cur_in = next_node;
         cnt_in = pos[9:0];
         act_in = !(pos + 11'd1 >= eff_len);
         rsp_valid = 1'b1;
         rsp.walk_node = next_node;
         rsp.position = pos[9:0];
         rsp.last = (pos + 11'd1 >= eff_len);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0; org_ff <= '0; prv_ff <= '0; cnt_ff <= '0;
         act_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in; org_ff <= org_in; prv_ff <= prv_in; cnt_ff <= cnt_in;
         act_ff <= act_in;
      end
   end
endmodule
`default_nettype wire
